[hdl/ffba_pkg.sv]
// Package for the first-fit block allocator: sequencer states, result status codes.
// Used by first_fit_block_allocator, ffba_checker and the testbench. No dependencies.
package ffba_pkg;

    localparam int GRANULE_SHIFT = 4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_INVALID = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_NULL    = 3'd4
    } ffba_status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ARD,
        S_ACK,
        S_ASPL,
        S_FRD,
        S_FCK,
        S_MRD,
        S_MCK,
        S_DONE
    } ffba_state_t;

endpackage

[hdl/first_fit_block_allocator.sv]
// First-fit block allocator: sequencer walking the block chain through one RAM.
// Depends on ffba_pkg and ffba_ram.
//
// Usage: one request beat on the input channel (mode, request_bytes,
// release_offset) gives exactly one result beat on the output channel.
// An allocate walks the block chain from granule zero until the first free
// block that fits; a free walks the chain until the payload offset matches,
// then merges with a free predecessor and up to two following blocks.
// Each visited block takes a RAM read state and then a check of the registered
// data, so the work for an item grows with the number of blocks visited; the
// chain walk goes through the single table port.
// in_stall is high while an item is in work.
// After reset the block writes the initial free block into the table (S_INIT)
// before taking the first request.
// The result sits in an output register; the next request is accepted while
// it waits. If out_stall is still high when the next result is ready, the
// sequencer holds that result and keeps in_stall high until the register frees.
module first_fit_block_allocator #(
    parameter int REGION_GRANULES = 1024,
    parameter int HEADER_GRANULES = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [14:0] request_bytes,
    input  logic [13:0] release_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] payload_offset,
    output logic [2:0]  status,
    output logic [14:0] free_byte_total,
    output logic [15:0] error_total,
    output logic [1:0]  error_marks
);

    import ffba_pkg::*;

    localparam int AW = $clog2(REGION_GRANULES);
    localparam int DW = AW + 1;
    localparam int CW = (AW + 2 > 12) ? AW + 2 : 12;
    localparam logic [CW-1:0] REGION = CW'(REGION_GRANULES);
    localparam logic [CW-1:0] HDR    = CW'(HEADER_GRANULES);
    localparam logic [CW-1:0] INIT_SIZE = CW'(REGION_GRANULES - HEADER_GRANULES);

    ffba_state_t state_reg, state_next;
    logic [CW-1:0] g_reg, g_next;
    logic [CW-1:0] need_reg, need_next;
    logic [13:0]   off_reg, off_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [CW-1:0] prev_size_reg, prev_size_next;
    logic          prev_free_reg, prev_free_next;
    logic          has_prev_reg, has_prev_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] cur_size_reg, cur_size_next;
    logic          second_reg, second_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   err_reg, err_next;
    logic [1:0]    marks_reg, marks_next;
    logic [13:0]   res_off_reg, res_off_next;
    ffba_status_t  res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [13:0]   out_off_reg, out_off_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [14:0]   out_free_reg, out_free_next;
    logic [15:0]   out_err_reg, out_err_next;
    logic [1:0]    out_marks_reg, out_marks_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    logic          d_free;
    logic [CW-1:0] d_size;
    logic [CW-1:0] walk_next;
    logic [CW-1:0] rest;
    logic [CW-1:0] merge_n;
    logic [CW-1:0] combined;
    logic [31:0]   off_bytes;
    logic [31:0]   free_byte_sum;
    logic          off_match;

    ffba_ram #(
        .WIDTH(DW),
        .DEPTH(REGION_GRANULES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign d_free    = rd_data[DW-1];
    assign d_size    = CW'(rd_data[AW-1:0]);
    assign walk_next = g_reg + HDR + d_size;
    assign rest      = d_size - need_reg;
    assign merge_n   = cur_reg + HDR + cur_size_reg;
    assign combined  = prev_size_reg + HDR + d_size;
    assign off_match = (g_reg + HDR == CW'(off_reg[13:GRANULE_SHIFT]))
                       && (off_reg[GRANULE_SHIFT-1:0] == '0);
    assign off_bytes     = 32'(g_reg + HDR) << GRANULE_SHIFT;
    assign free_byte_sum = 32'(cnt_reg) << GRANULE_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= INIT_SIZE;
            err_reg       <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
            has_prev_reg  <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
            has_prev_reg  <= has_prev_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg          <= g_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        prev_free_reg  <= prev_free_next;
        cur_reg        <= cur_next;
        cur_size_reg   <= cur_size_next;
        res_off_reg    <= res_off_next;
        res_status_reg <= res_status_next;
        out_off_reg    <= out_off_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        out_err_reg    <= out_err_next;
        out_marks_reg  <= out_marks_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        g_next          = g_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        prev_free_next  = prev_free_reg;
        has_prev_next   = has_prev_reg;
        cur_next        = cur_reg;
        cur_size_next   = cur_size_reg;
        second_next     = second_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        marks_next      = marks_reg;
        res_off_next    = res_off_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_off_next    = out_off_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_err_next    = out_err_reg;
        out_marks_next  = out_marks_reg;
        in_stall        = 1'b1;
        wr_en           = 1'b0;
        wr_addr         = g_reg[AW-1:0];
        wr_data         = '0;
        rd_addr         = g_reg[AW-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {1'b1, INIT_SIZE[AW-1:0]};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    g_next          = '0;
                    has_prev_next   = 1'b0;
                    second_next     = 1'b0;
                    res_off_next    = '0;
                    res_status_next = ST_OK;
                    off_next        = release_offset;
                    need_next = CW'((16'(request_bytes) + 16'd15) >> GRANULE_SHIFT);
                    if (!mode)
                    begin
                        if (request_bytes == '0)
                        begin
                            res_status_next = ST_NO_FIT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ARD;
                        end
                    end
                    else if (release_offset == '0)
                    begin
                        res_status_next = ST_NULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_ARD:
            begin
                if (g_reg >= REGION)
                begin
                    res_status_next = ST_NO_FIT;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (d_free && d_size >= need_reg)
                begin
                    res_off_next = off_bytes[13:0];
                    if (rest >= HDR + CW'(1))
                    begin
                        // split: the tail becomes a new free block
                        wr_en      = 1'b1;
                        wr_addr    = AW'(g_reg + HDR + need_reg);
                        wr_data    = {1'b1, AW'(rest - HDR)};
                        cnt_next   = cnt_reg - need_reg - HDR;
                        state_next = S_ASPL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {1'b0, d_size[AW-1:0]};
                        cnt_next   = cnt_reg - d_size;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    g_next     = walk_next;
                    state_next = S_ARD;
                end
            end
            S_ASPL:
            begin
                wr_en      = 1'b1;
                wr_data    = {1'b0, need_reg[AW-1:0]};
                state_next = S_DONE;
            end
            S_FRD:
            begin
                if (g_reg >= REGION)
                begin
                    res_status_next = ST_INVALID;
                    err_next        = (err_reg == 16'hFFFF) ? err_reg : err_reg + 16'd1;
                    marks_next      = marks_reg | 2'b01;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FCK;
                end
            end
            S_FCK:
            begin
                if (off_match)
                begin
                    if (d_free)
                    begin
                        res_status_next = ST_DOUBLE;
                        err_next   = (err_reg == 16'hFFFF) ? err_reg : err_reg + 16'd1;
                        marks_next = marks_reg | 2'b10;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (has_prev_reg && prev_free_reg)
                        begin
                            // fold into the free predecessor
                            cur_next      = prev_reg;
                            cur_size_next = combined;
                            cnt_next      = cnt_reg + d_size + HDR;
                            wr_addr       = prev_reg[AW-1:0];
                            wr_data       = {1'b1, combined[AW-1:0]};
                        end
                        else
                        begin
                            cur_next      = g_reg;
                            cur_size_next = d_size;
                            cnt_next      = cnt_reg + d_size;
                            wr_data       = {1'b1, d_size[AW-1:0]};
                        end
                        state_next = S_MRD;
                    end
                end
                else
                begin
                    prev_next      = g_reg;
                    prev_size_next = d_size;
                    prev_free_next = d_free;
                    has_prev_next  = 1'b1;
                    g_next         = walk_next;
                    state_next     = S_FRD;
                end
            end
            S_MRD:
            begin
                rd_addr = merge_n[AW-1:0];
                g_next  = merge_n;
                if (merge_n >= REGION)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MCK;
                end
            end
            S_MCK:
            begin
                if (d_free)
                begin
                    cur_size_next = cur_size_reg + HDR + d_size;
                    cnt_next      = cnt_reg + HDR;
                    wr_en         = 1'b1;
                    wr_addr       = cur_reg[AW-1:0];
                    wr_data       = {1'b1, AW'(cur_size_reg + HDR + d_size)};
                    second_next   = 1'b1;
                    state_next    = second_reg ? S_DONE : S_MRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_off_next    = res_off_reg;
                    out_status_next = res_status_reg;
                    out_free_next   = free_byte_sum[14:0];
                    out_err_next    = err_reg;
                    out_marks_next  = marks_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign payload_offset  = out_off_reg;
    assign status          = out_status_reg;
    assign free_byte_total = out_free_reg;
    assign error_total     = out_err_reg;
    assign error_marks     = out_marks_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= INIT_SIZE)
        else $error("free granule count beyond region payload");

    a_marks_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == '0) == (marks_reg == '0))
        else $error("error marks disagree with error count");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg <= ST_NULL))
        else $error("result status out of range");

    a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg >= $past(err_reg))
        else $error("error count decreased");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACK || state_reg == S_FCK) |-> (g_reg < REGION))
        else $error("walk pointer past region end");

endmodule

[hdl/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sim/ffba_checker.sv]
// Scoreboard for the first-fit block allocator: predicts each result beat from the
// request beats it sees and compares field by field. Depends on ffba_pkg.
module ffba_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [14:0] request_bytes,
    input  logic [13:0] release_offset,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [13:0] payload_offset,
    input  logic [2:0]  status,
    input  logic [14:0] free_byte_total,
    input  logic [15:0] error_total,
    input  logic [1:0]  error_marks,
    output int          fail_count,
    output int          pending
);
    import ffba_pkg::*;

    localparam int GRANULES = 1024;
    localparam int HDR      = 2;

    typedef struct {
        logic [13:0]  offset;
        ffba_status_t code;
        logic [14:0]  avail_sum;
        logic [15:0]  errors;
        logic [1:0]   marks;
    } alloc_result_t;

    int unsigned   payload_len[GRANULES];
    bit            is_free[GRANULES];
    int unsigned   err_count;
    logic [1:0]    err_marks;
    alloc_result_t result_queue[$];

    function automatic int unsigned chain_next(int unsigned g);
        return g + HDR + payload_len[g];
    endfunction

    function automatic void absorb_next(int unsigned g);
        int unsigned n;
        n = chain_next(g);
        if (!is_free[g] || n >= GRANULES || !is_free[n])
            return;
        payload_len[g] += HDR + payload_len[n];
        payload_len[n] = 0;
        is_free[n] = 0;
    endfunction

    function automatic void raise_error(logic [1:0] bit_mask);
        if (err_count < 65535)
            err_count++;
        err_marks |= bit_mask;
    endfunction

    function automatic alloc_result_t serve_request(logic m, logic [14:0] req,
                                                    logic [13:0] off);
        alloc_result_t r;
        int unsigned   need, g, prev, rest, sum;
        bit            found, has_prev;
        r.offset = '0;
        r.code = ST_OK;
        found = 0;
        has_prev = 0;
        prev = 0;
        g = 0;
        if (m == 1'b0)
        begin
            need = (int'(req) + 15) / 16;
            if (need != 0)
            begin
                while (g < GRANULES)
                begin
                    if (is_free[g] && payload_len[g] >= need)
                    begin
                        found = 1;
                        break;
                    end
                    g = chain_next(g);
                end
            end
            if (!found)
                r.code = ST_NO_FIT;
            else
            begin
                rest = payload_len[g] - need;
                if (rest >= HDR + 1)
                begin
                    payload_len[g + HDR + need] = rest - HDR;
                    is_free[g + HDR + need] = 1;
                    payload_len[g] = need;
                end
                is_free[g] = 0;
                r.offset = 14'((g + HDR) * 16);
            end
        end
        else if (off == '0)
            r.code = ST_NULL;
        else
        begin
            while (g < GRANULES)
            begin
                if ((g + HDR) * 16 == off)
                begin
                    found = 1;
                    break;
                end
                prev = g;
                has_prev = 1;
                g = chain_next(g);
            end
            if (!found)
            begin
                r.code = ST_INVALID;
                raise_error(2'b01);
            end
            else if (is_free[g])
            begin
                r.code = ST_DOUBLE;
                raise_error(2'b10);
            end
            else
            begin
                is_free[g] = 1;
                if (has_prev && is_free[prev])
                    g = prev;
                absorb_next(g);
                absorb_next(g);
            end
        end
        sum = 0;
        g = 0;
        while (g < GRANULES)
        begin
            if (is_free[g])
                sum += payload_len[g] * 16;
            g = chain_next(g);
        end
        r.avail_sum = 15'(sum);
        r.errors = 16'(err_count);
        r.marks = err_marks;
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < GRANULES; i++)
        begin
            payload_len[i] = 0;
            is_free[i] = 0;
        end
        payload_len[0] = GRANULES - HDR;
        is_free[0] = 1;
        err_count = 0;
        err_marks = '0;
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && in_valid && !in_stall)
            result_queue.push_back(serve_request(mode, request_bytes, release_offset));
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_queue.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                fail_count++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (payload_offset !== want.offset)
                begin
                    $display("%0t: payload_offset expected %0d got %0d",
                             $time, want.offset, payload_offset);
                    fail_count++;
                end
                if (status !== want.code)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.code, status);
                    fail_count++;
                end
                if (free_byte_total !== want.avail_sum)
                begin
                    $display("%0t: free_byte_total expected %0d got %0d",
                             $time, want.avail_sum, free_byte_total);
                    fail_count++;
                end
                if (error_total !== want.errors)
                begin
                    $display("%0t: error_total expected %0d got %0d",
                             $time, want.errors, error_total);
                    fail_count++;
                end
                if (error_marks !== want.marks)
                begin
                    $display("%0t: error_marks expected %0d got %0d",
                             $time, want.marks, error_marks);
                    fail_count++;
                end
            end
        end
        pending <= result_queue.size();
    end

endmodule

[sim/tb_first_fit_block_allocator.sv]
// Testbench top for first_fit_block_allocator: drives request beats, stalls the
// result channel and gives the verdict. Depends on ffba_pkg and ffba_checker.
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int RANDOM_ITEMS = 1630;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [14:0] request_bytes;
    logic [13:0] release_offset;
    logic        out_valid;
    logic        out_stall;
    logic [13:0] payload_offset;
    logic [2:0]  status;
    logic [14:0] free_byte_total;
    logic [15:0] error_total;
    logic [1:0]  error_marks;
    int          fail_count;
    int          pending;
    int          sent;
    int          received;
    bit          steady;
    logic [13:0] live_blocks[$];
    logic [13:0] released[$];

    first_fit_block_allocator u_top (.*);

    ffba_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 4000000);
        $display("tb_first_fit_block_allocator: errors");
        $finish;
    end

    // Track granted offsets so that most frees hit real blocks.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            received <= received + 1;
            if (mode_is_grant(status, payload_offset))
                live_blocks.push_back(payload_offset);
        end
    end

    function automatic bit mode_is_grant(logic [2:0] s, logic [13:0] off);
        return s == ST_OK && off != '0;
    endfunction

    task automatic send_beat(logic m, logic [14:0] req, logic [13:0] off);
        int gap;
        gap = steady ? 0 : $urandom_range(17, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        request_bytes <= req;
        release_offset <= off;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_release(logic [13:0] off);
        send_beat(1'b1, 15'($urandom), off);
    endtask

    task automatic send_alloc(logic [14:0] req);
        send_beat(1'b0, req, 14'($urandom));
    endtask

    // Receiver: random hold per beat, one long hold to back the block up.
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (received == 300)
                hold = 400;
            else if (steady)
                hold = 0;
            else
                hold = $urandom_range(17, 0);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int pick, idx;
        logic [13:0] off;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        request_bytes = '0;
        release_offset = '0;
        sent = 0;
        received = 0;
        steady = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, oversize, small blocks, every free outcome, full fit.
        send_alloc(15'd0);
        send_alloc(15'd16384);
        send_alloc(15'd1);
        send_alloc(15'd16);
        send_alloc(15'd17);
        send_release(14'd0);
        send_release(14'd1);
        send_release(14'h3fff);
        send_release(14'd80);
        send_release(14'd80);
        send_release(14'd32);
        send_release(14'd128);
        send_alloc(15'd16352);
        send_alloc(15'd1);
        send_release(14'd32);
        send_alloc(15'd16337);
        send_release(14'd32);
        send_alloc(15'd16321);
        send_alloc(15'd16);
        send_release(14'd32);
        send_release(14'd16336);
        live_blocks.delete();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 700 && i < 820);
            pick = $urandom_range(99, 0);
            if (live_blocks.size() > 0 && pick < 45) begin
                idx = $urandom_range(live_blocks.size() - 1, 0);
                off = live_blocks[idx];
                live_blocks.delete(idx);
                released.push_back(off);
                send_release(off);
            end
            else if (pick < 50 && released.size() > 0)
                send_release(released[$urandom_range(released.size() - 1, 0)]);
            else if (pick < 56)
                send_release(14'($urandom));
            else if (pick < 59)
                send_release(14'd0);
            else if (pick < 62)
                send_alloc(15'd0);
            else if (pick < 80)
                send_alloc(15'($urandom_range(300, 1)));
            else if (pick < 96)
                send_alloc(15'($urandom_range(2000, 1)));
            else
                send_alloc(15'($urandom_range(16384, 0)));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0 || received < sent);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_first_fit_block_allocator: clean");
        else
            $display("tb_first_fit_block_allocator: errors");
        $finish;
    end

endmodule
